// ===== rtl/core/tkbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch key baseline detector package
// Shared constants, item and result types for the detector core.
// ----------------------------------------------------------------------------
package tkbd_pkg;

    localparam int RUN_LENGTH_DEF = 50;
    localparam int FIFO_DEPTH_DEF = 16;

    localparam int SAMPLE_W = 16;
    localparam int GATE_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [GATE_W-1:0] GATE_RESET = 16'd50;

    localparam logic [APB_ADDR_W-1:0] ADDR_ENABLE = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_GATE   = 3'd4;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam logic EVT_TOUCH   = 1'b0;
    localparam logic EVT_RELEASE = 1'b1;

    // What the back end has to do with a queued transaction.
    typedef enum logic [1:0] {
        KIND_REFUSED = 2'd0,
        KIND_SAMPLE  = 2'd1,
        KIND_POP     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_IDLE    = 2'd0,
        DIR_TOUCH   = 2'd1,
        DIR_RELEASE = 2'd2
    } dir_t;

    typedef struct packed {
        kind_t               kind;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic status;
        logic event_valid;
        logic event_code;
        logic dropped;
    } result_t;

endpackage

// ===== rtl/core/touch_key_baseline_detector_core.sv =====
// A transaction accepted at s_ passes the front-end queue and the result register to m_.
// Throughput: one transaction per cycle while m_tready is high; a sample that completes
// a run stalls the back end while the reciprocal divider forms the new baseline.
// Reset: aresetn is synchronous and active low; it clears the baseline tracker,
// the event FIFO pointers, the queue and the registers (enable 0, gate 50).
// The event FIFO storage itself is not cleared; entries are written before read.
// ----------------------------------------------------------------------------
// Touch key baseline detector core
// Capacitive key detector with adaptive baseline, run averaging and event FIFO.
// ----------------------------------------------------------------------------
module touch_key_baseline_detector_core #(
    parameter int RUN_LENGTH = tkbd_pkg::RUN_LENGTH_DEF,
    parameter int FIFO_DEPTH = tkbd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream. s_tdata: [0] cmd, [16:1] sample, [23:17] zero.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    // Result stream. m_tdata: [0] status, [1] event_valid, [2] event_code,
    // [3] dropped, [7:4] zero.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tkbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tkbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tkbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    logic                        enable_reg, enable_next;
    logic [tkbd_pkg::GATE_W-1:0] gate_reg, gate_next;
    logic                        cfg_write;
    logic                        item_valid;
    tkbd_pkg::item_t             item;
    logic                        item_take;
    tkbd_pkg::result_t           result;

    // The register port never waits. A register takes its value on the access
    // cycle of a write transaction; addresses outside the map are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb begin
        enable_next = enable_reg;
        gate_next   = gate_reg;
        if (cfg_write) begin
            case (paddr)
                tkbd_pkg::ADDR_ENABLE: enable_next = pwdata[0];
                tkbd_pkg::ADDR_GATE:   gate_next   = pwdata[tkbd_pkg::GATE_W-1:0];
                default: begin
                    enable_next = enable_reg;
                    gate_next   = gate_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            tkbd_pkg::ADDR_ENABLE: prdata = {{(tkbd_pkg::APB_DATA_W-1){1'b0}}, enable_reg};
            tkbd_pkg::ADDR_GATE:
                prdata = {{(tkbd_pkg::APB_DATA_W-tkbd_pkg::GATE_W){1'b0}}, gate_reg};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            gate_reg   <= tkbd_pkg::GATE_RESET;
        end else begin
            enable_reg <= enable_next;
            gate_reg   <= gate_next;
        end
    end

    // The front end tags each transaction as refused, sample or pop and queues
    // it, so new input keeps flowing while the back end waits on the divider
    // or on a stalled result.
    tkbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_cmd      (s_tdata[0]),
        .s_sample   (s_tdata[16:1]),
        .enable     (enable_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // The back end owns all tracker state. It compares each sample against the
    // baseline plus or minus the gate, accumulates runs, pushes touch and
    // release events, serves pops, and holds one result in its output register.
    tkbd_back #(
        .RUN_LENGTH (RUN_LENGTH),
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gate       (gate_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .result     (result)
    );

    assign m_tdata = {4'b0000, result.dropped, result.event_code,
                      result.event_valid, result.status};

endmodule

// ===== rtl/core/tkbd_front.sv =====
// ----------------------------------------------------------------------------
// Touch key detector front end
// Classifies incoming transactions and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tkbd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_cmd,
    input  logic [tkbd_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                          enable,
    output logic                          item_valid,
    output tkbd_pkg::item_t               item,
    input  logic                          item_take
);

    tkbd_pkg::item_t slot_reg [2];
    tkbd_pkg::item_t in_item;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    logic            pop;

    // A disabled device refuses everything, so the decision is made on entry.
    always_comb begin
        in_item.sample = s_sample;
        if (!enable) begin
            in_item.kind = tkbd_pkg::KIND_REFUSED;
        end else if (s_cmd == tkbd_pkg::CMD_POP) begin
            in_item.kind = tkbd_pkg::KIND_POP;
        end else begin
            in_item.kind = tkbd_pkg::KIND_SAMPLE;
        end
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid & s_tready;
    assign pop        = item_take & item_valid;
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/tkbd_div.sv =====
// ----------------------------------------------------------------------------
// Touch key detector run average divider
// Divides a run sum by the run length with a reciprocal multiply and one fix-up.
// ----------------------------------------------------------------------------
module tkbd_div #(
    parameter int RUN_LENGTH = tkbd_pkg::RUN_LENGTH_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  start,
    input  logic [tkbd_pkg::SAMPLE_W+$clog2(RUN_LENGTH)-1:0]      dividend,
    output logic                                                  busy,
    output logic                                                  done,
    output logic [tkbd_pkg::SAMPLE_W-1:0]                         quotient
);

    localparam int SUM_W     = tkbd_pkg::SAMPLE_W + $clog2(RUN_LENGTH);
    localparam int DIV_SHIFT = SUM_W + $clog2(RUN_LENGTH);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int RL_W      = $clog2(RUN_LENGTH + 1);
    localparam int REM_W     = RL_W + 1;
    localparam int BACK_W    = SUM_W + RL_W;

    // floor(2^DIV_SHIFT / RUN_LENGTH) underestimates the quotient by at most one.
    localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << DIV_SHIFT) / RUN_LENGTH);
    localparam logic [RL_W-1:0]    DIVISOR = RL_W'(RUN_LENGTH);
    localparam logic [REM_W-1:0]   DIVISOR_R = REM_W'(RUN_LENGTH);

    logic                          a_valid_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [SUM_W-1:0]              x_reg;
    logic                          b_valid_reg;
    logic [tkbd_pkg::SAMPLE_W-1:0] q_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [SUM_W-1:0]              q_est;
    logic [BACK_W-1:0]             back_prod;
    logic [SUM_W-1:0]              rem_full;

    assign q_est     = prod_reg[DIV_SHIFT +: SUM_W];
    assign back_prod = BACK_W'(q_est) * BACK_W'(DIVISOR);
    assign rem_full  = x_reg - back_prod[SUM_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= start;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(dividend) * PROD_W'(RECIP);
        x_reg    <= dividend;
        q_reg    <= q_est[tkbd_pkg::SAMPLE_W-1:0];
        rem_reg  <= rem_full[REM_W-1:0];
    end

    assign busy     = a_valid_reg | b_valid_reg;
    assign done     = b_valid_reg;
    assign quotient = (rem_reg >= DIVISOR_R) ? q_reg + {{(tkbd_pkg::SAMPLE_W-1){1'b0}}, 1'b1}
                                             : q_reg;

endmodule

// ===== rtl/core/tkbd_back.sv =====
// ----------------------------------------------------------------------------
// Touch key detector back end
// Runs the baseline tracker, the event FIFO and the result register.
// ----------------------------------------------------------------------------
module tkbd_back #(
    parameter int RUN_LENGTH = tkbd_pkg::RUN_LENGTH_DEF,
    parameter int FIFO_DEPTH = tkbd_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tkbd_pkg::GATE_W-1:0] gate,
    input  logic                        item_valid,
    input  tkbd_pkg::item_t             item,
    output logic                        item_take,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output tkbd_pkg::result_t           result
);

    localparam int SAMPLE_W = tkbd_pkg::SAMPLE_W;
    localparam int SUM_W    = SAMPLE_W + $clog2(RUN_LENGTH);
    localparam int CNT_W    = $clog2(RUN_LENGTH + 1);
    localparam int PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FCNT_W   = $clog2(FIFO_DEPTH + 1);

    logic [SAMPLE_W-1:0] baseline_reg, baseline_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    tkbd_pkg::dir_t      dir_reg, dir_next;
    tkbd_pkg::dir_t      last_reg, last_next;
    logic [PTR_W-1:0]    wptr_reg, wptr_next;
    logic [PTR_W-1:0]    rptr_reg, rptr_next;
    logic [FCNT_W-1:0]   fcount_reg, fcount_next;
    logic                fifo_mem [FIFO_DEPTH];
    logic                out_valid_reg, out_valid_next;
    tkbd_pkg::result_t   out_reg;

    logic                fire;
    logic                is_sample;
    logic                is_pop;
    logic [SAMPLE_W:0]   upper;
    logic                below;
    tkbd_pkg::dir_t      side;
    logic                same;
    logic [CNT_W-1:0]    cnt_inc;
    logic [SUM_W-1:0]    sum_acc;
    logic                run_done;
    logic                report;
    logic                fifo_full;
    logic                fifo_empty;
    logic                push;
    logic                pop;
    logic                dropped;
    logic                code;
    logic                div_busy;
    logic                div_done;
    logic [SAMPLE_W-1:0] div_quot;

    tkbd_div #(
        .RUN_LENGTH (RUN_LENGTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (is_sample & run_done),
        .dividend (sum_acc),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // The back end halts while a new baseline is being computed.
    assign fire      = item_valid & ~div_busy & (~out_valid_reg | m_tready);
    assign item_take = fire;
    assign is_sample = fire & (item.kind == tkbd_pkg::KIND_SAMPLE);
    assign is_pop    = fire & (item.kind == tkbd_pkg::KIND_POP);

    // Release test is sample + gate < baseline, which avoids a negative bound.
    assign upper = {1'b0, baseline_reg} + {1'b0, gate};
    assign below = ({1'b0, item.sample} + {1'b0, gate}) < {1'b0, baseline_reg};

    always_comb begin
        if ({1'b0, item.sample} > upper) begin
            side = tkbd_pkg::DIR_TOUCH;
        end else if (below) begin
            side = tkbd_pkg::DIR_RELEASE;
        end else begin
            side = tkbd_pkg::DIR_IDLE;
        end
    end

    assign same     = (dir_reg == side);
    assign cnt_inc  = (same ? cnt_reg : '0) + CNT_W'(1);
    assign sum_acc  = (same ? sum_reg : '0) + SUM_W'(item.sample);
    assign run_done = (side != tkbd_pkg::DIR_IDLE) && (cnt_inc == CNT_W'(RUN_LENGTH));

    assign report     = run_done && (baseline_reg != '0) && (last_reg != side);
    assign fifo_full  = (fcount_reg == FCNT_W'(FIFO_DEPTH));
    assign fifo_empty = (fcount_reg == '0);
    assign push       = is_sample & report & ~fifo_full;
    assign dropped    = report & fifo_full;
    assign pop        = is_pop & ~fifo_empty;
    assign code       = (side == tkbd_pkg::DIR_RELEASE) ? tkbd_pkg::EVT_RELEASE
                                                       : tkbd_pkg::EVT_TOUCH;

    always_comb begin
        baseline_next = div_done ? div_quot : baseline_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        dir_next      = dir_reg;
        last_next     = last_reg;
        if (is_sample) begin
            dir_next = side;
            if (side == tkbd_pkg::DIR_IDLE || run_done) begin
                cnt_next = '0;
                sum_next = '0;
            end else begin
                cnt_next = cnt_inc;
                sum_next = sum_acc;
            end
            if (run_done && baseline_reg != '0) begin
                last_next = side;
            end
        end
    end

    always_comb begin
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        fcount_next = fcount_reg;
        if (push) begin
            wptr_next   = (wptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
            fcount_next = fcount_reg + FCNT_W'(1);
        end
        if (pop) begin
            rptr_next   = (rptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
            fcount_next = fcount_reg - FCNT_W'(1);
        end
    end

    assign out_valid_next = fire | (out_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg  <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            dir_reg       <= tkbd_pkg::DIR_IDLE;
            last_reg      <= tkbd_pkg::DIR_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            fcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            baseline_reg  <= baseline_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            dir_reg       <= dir_next;
            last_reg      <= last_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            fcount_reg    <= fcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Event storage and the result register carry payload only.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wptr_reg] <= code;
        end
        if (fire) begin
            out_reg.status      <= (item.kind == tkbd_pkg::KIND_REFUSED);
            out_reg.event_valid <= pop;
            out_reg.event_code  <= pop ? fifo_mem[rptr_reg] : 1'b0;
            out_reg.dropped     <= is_sample & dropped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

endmodule

// ===== tb/tb_touch_key_baseline_detector_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch key baseline detector core testbench
// Sends capture samples and event pops through the input stream, configures
// the device over the register port and checks every result transaction
// against an in-bench tracker of baseline, runs and the event queue.
// ----------------------------------------------------------------------------
module tb_touch_key_baseline_detector_core;

    localparam int RUN_LEN     = tkbd_pkg::RUN_LENGTH_DEF;
    localparam int EVT_DEPTH   = tkbd_pkg::FIFO_DEPTH_DEF;
    localparam int MAX_CAPTURE = 65535;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [23:0]                     s_tdata  = '0;   // [0] cmd, [16:1] sample, [23:17] zero
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;         // [0] status, [1] event_valid,
                                                      // [2] event_code, [3] dropped,
                                                      // [7:4] zero
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [tkbd_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [tkbd_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [tkbd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    touch_key_baseline_detector_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Key tracker: our own copy of the device state, advanced once for every
    // accepted input transaction. The registers start at their reset values.
    // ------------------------------------------------------------------------
    logic           open_q     = 1'b0;
    logic [15:0]    gate_q     = tkbd_pkg::GATE_RESET;
    logic [15:0]    base_q     = '0;
    logic [21:0]    sum_q      = '0;
    int unsigned    count_q    = 0;
    tkbd_pkg::dir_t dir_q      = tkbd_pkg::DIR_IDLE;
    tkbd_pkg::dir_t reported_q = tkbd_pkg::DIR_IDLE;
    logic           events_q [EVT_DEPTH];
    int unsigned    wr_q       = 0;
    int unsigned    rd_q       = 0;
    int unsigned    level_q    = 0;
    bit             run_closed = 1'b0;   // the last sample completed a run

    // Results owed by the device, oldest first.
    tkbd_pkg::result_t reports_due [$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;

    // When set, neither side inserts idle cycles.
    bit          steady     = 1'b0;

    // Long receiver hold-off, requested by a test and counted down below.
    int unsigned hold_len   = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;

    task automatic flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Advances the tracker by one transaction and returns the result it owes.
    function automatic tkbd_pkg::result_t track_key_item(logic cmd, logic [15:0] capture);
        tkbd_pkg::result_t res;
        int                cap;
        int                upper;
        int                lower;
        tkbd_pkg::dir_t    side;
        res        = '0;
        run_closed = 1'b0;
        // A closed device refuses everything and keeps its state.
        if (!open_q) begin
            res.status = 1'b1;
            return res;
        end
        if (cmd == tkbd_pkg::CMD_POP) begin
            if (level_q != 0) begin
                res.event_valid = 1'b1;
                res.event_code  = events_q[rd_q];
                rd_q            = (rd_q + 1) % EVT_DEPTH;
                level_q--;
            end
            return res;
        end
        // Signed comparison: the lower edge may fall below zero.
        cap   = int'(capture);
        upper = int'(base_q) + int'(gate_q);
        lower = int'(base_q) - int'(gate_q);
        if (cap > upper)
            side = tkbd_pkg::DIR_TOUCH;
        else if (cap < lower)
            side = tkbd_pkg::DIR_RELEASE;
        else
            side = tkbd_pkg::DIR_IDLE;
        if (side == tkbd_pkg::DIR_IDLE) begin
            count_q = 0;
            sum_q   = '0;
            dir_q   = tkbd_pkg::DIR_IDLE;
        end else begin
            if (dir_q != side) begin
                count_q = 0;
                sum_q   = '0;
                dir_q   = side;
            end
            count_q++;
            sum_q += 22'(capture);
        end
        if (count_q >= RUN_LEN) begin
            // A run from a zero baseline only sets the baseline.
            if (base_q != 0) begin
                if (reported_q != dir_q) begin
                    if (level_q >= EVT_DEPTH) begin
                        res.dropped = 1'b1;
                    end else begin
                        events_q[wr_q] = (dir_q == tkbd_pkg::DIR_RELEASE)
                                         ? tkbd_pkg::EVT_RELEASE : tkbd_pkg::EVT_TOUCH;
                        wr_q           = (wr_q + 1) % EVT_DEPTH;
                        level_q++;
                    end
                end
                reported_q = dir_q;
            end
            base_q     = 16'(sum_q / RUN_LEN);
            count_q    = 0;
            sum_q      = '0;
            run_closed = 1'b1;
        end
        return res;
    endfunction

    // Range of capture values that land on a side of the current baseline,
    // at most span wide. Returns 0 when that side cannot be reached.
    function automatic bit side_bounds(tkbd_pkg::dir_t side, int span,
                                       output int lo, output int hi);
        int b;
        int g;
        b = int'(base_q);
        g = int'(gate_q);
        if (side == tkbd_pkg::DIR_TOUCH) begin
            lo = b + g + 1;
            hi = (lo + span > MAX_CAPTURE) ? MAX_CAPTURE : lo + span;
            return lo <= MAX_CAPTURE;
        end
        if (side == tkbd_pkg::DIR_RELEASE) begin
            hi = b - g - 1;
            lo = (hi - span < 0) ? 0 : hi - span;
            return hi >= 0;
        end
        lo = (b - g < 0) ? 0 : b - g;
        hi = (b + g > MAX_CAPTURE) ? MAX_CAPTURE : b + g;
        return 1'b1;
    endfunction

    // Prefers the side that yields a new event, falls back to the other one.
    function automatic tkbd_pkg::dir_t pick_side();
        int             lo;
        int             hi;
        tkbd_pkg::dir_t want;
        tkbd_pkg::dir_t other;
        if (reported_q == tkbd_pkg::DIR_TOUCH) begin
            want  = tkbd_pkg::DIR_RELEASE;
            other = tkbd_pkg::DIR_TOUCH;
        end else begin
            want  = tkbd_pkg::DIR_TOUCH;
            other = tkbd_pkg::DIR_RELEASE;
        end
        if (side_bounds(want, 0, lo, hi))
            return want;
        if (side_bounds(other, 0, lo, hi))
            return other;
        return tkbd_pkg::DIR_IDLE;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------------

    // Offers one transaction and waits until the device takes it. Valid stays
    // high after acceptance so back-to-back transactions need no gap.
    task automatic send_item(logic cmd, logic [15:0] capture);
        while (!steady && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, capture, cmd};
        do @(posedge aclk); while (!s_tready);
        reports_due.push_back(track_key_item(cmd, capture));
        items_sent++;
    endtask

    // Sends samples on one side until a run completes or max_samples have gone,
    // with pops mixed in at the given percentage.
    task automatic send_run(tkbd_pkg::dir_t side, int pop_pct, int max_samples);
        int lo;
        int hi;
        int span;
        int n;
        if (side == tkbd_pkg::DIR_IDLE)
            return;
        span = ($urandom_range(3) == 0) ? $urandom_range(MAX_CAPTURE) : $urandom_range(300);
        n    = 0;
        while (n < max_samples && side_bounds(side, span, lo, hi)) begin
            if ($urandom_range(99) < pop_pct) begin
                send_item(tkbd_pkg::CMD_POP, 16'($urandom));
            end else begin
                send_item(tkbd_pkg::CMD_SAMPLE, 16'($urandom_range(hi, lo)));
                n++;
                if (run_closed)
                    break;
            end
        end
    endtask

    // One stray transaction: a pop, a sample inside the gate, or any sample.
    task automatic send_noise();
        int lo;
        int hi;
        case ($urandom_range(3))
            0: send_item(tkbd_pkg::CMD_POP, 16'($urandom));
            1: begin
                void'(side_bounds(tkbd_pkg::DIR_IDLE, 0, lo, hi));
                send_item(tkbd_pkg::CMD_SAMPLE, 16'($urandom_range(hi, lo)));
            end
            default: send_item(tkbd_pkg::CMD_SAMPLE, 16'($urandom));
        endcase
    endtask

    // Stops offering and waits for every owed result, with a limit.
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (reports_due.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", reports_due.size()));
            reports_due.delete();
        end
    endtask

    // One register transaction: setup cycle, then access until pready. A write
    // also updates the tracker; a read is checked against the tracker's copy.
    task automatic cfg_access(bit is_write, logic [tkbd_pkg::APB_ADDR_W-1:0] addr,
                              logic [31:0] value);
        logic [31:0] want;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (is_write) begin
            if (addr == tkbd_pkg::ADDR_ENABLE)
                open_q = value[0];
            else if (addr == tkbd_pkg::ADDR_GATE)
                gate_q = value[15:0];
        end else begin
            want = (addr == tkbd_pkg::ADDR_ENABLE) ? 32'(open_q) : 32'(gate_q);
            if (prdata !== want)
                flag_mismatch($sformatf("register %0d read %0h, want %0h", addr, prdata, want));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: ready with random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_seen != hold_asked) begin
            hold_seen <= hold_asked;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // Every result transaction is matched, field by field, with the oldest
    // owed result.
    always @(posedge aclk) begin : result_check
        tkbd_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reports_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %0h", m_tdata));
            end else begin
                want = reports_due.pop_front();
                if (m_tdata[0] !== want.status)
                    flag_mismatch($sformatf("status %b, want %b", m_tdata[0], want.status));
                if (m_tdata[1] !== want.event_valid)
                    flag_mismatch($sformatf("event_valid %b, want %b",
                                            m_tdata[1], want.event_valid));
                if (m_tdata[2] !== want.event_code)
                    flag_mismatch($sformatf("event_code %b, want %b",
                                            m_tdata[2], want.event_code));
                if (m_tdata[3] !== want.dropped)
                    flag_mismatch($sformatf("dropped %b, want %b", m_tdata[3], want.dropped));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the device is closed: registers read back their reset
    // values and every transaction is refused without touching the state.
    task automatic test_closed_device();
        cfg_access(1'b0, tkbd_pkg::ADDR_ENABLE, '0);
        cfg_access(1'b0, tkbd_pkg::ADDR_GATE, '0);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(tkbd_pkg::CMD_POP, 16'h0000);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h0000);
        wait_drained();
    endtask

    // Field extremes and the gate at both ends while the baseline is still
    // zero, so the release side is out of reach.
    task automatic test_field_extremes();
        cfg_access(1'b1, tkbd_pkg::ADDR_ENABLE, 32'd1);
        cfg_access(1'b0, tkbd_pkg::ADDR_ENABLE, '0);
        send_item(tkbd_pkg::CMD_POP, 16'hFFFF);          // nothing queued yet
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h0000);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'd50);         // right on the upper edge: idle
        send_item(tkbd_pkg::CMD_SAMPLE, 16'd51);         // just above: touch side
        send_item(tkbd_pkg::CMD_SAMPLE, 16'hFFFF);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h5555);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'hAAAA);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h0000);       // idle sample clears the run
        wait_drained();
        cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'd0);
        cfg_access(1'b0, tkbd_pkg::ADDR_GATE, '0);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h0000);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'h0001);
        wait_drained();
        cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'd65535);
        send_item(tkbd_pkg::CMD_SAMPLE, 16'hFFFF);       // no side reachable at all
        send_item(tkbd_pkg::CMD_POP, 16'h0000);
        wait_drained();
    endtask

    // The first run only sets the baseline; then alternating runs produce
    // events until the queue is full and further events are dropped. The
    // sender then pauses for every owed result before draining the queue.
    task automatic test_event_overflow();
        cfg_access(1'b1, tkbd_pkg::ADDR_GATE, $urandom_range(200, 20));
        repeat (EVT_DEPTH + 3) send_run(pick_side(), 0, 2 * RUN_LEN);
        wait_drained();
        repeat (EVT_DEPTH + 2) send_item(tkbd_pkg::CMD_POP, 16'($urandom));
        wait_drained();
    endtask

    // The receiver holds off for a long time while the sender keeps offering,
    // so the device fills up and stalls its input. No idling on either side.
    task automatic test_back_pressure();
        steady     = 1'b1;
        hold_len   <= 300;
        hold_asked <= hold_asked + 1;
        repeat (3) send_run(pick_side(), 20, 2 * RUN_LEN);
        wait_drained();
        steady = 1'b0;
    endtask

    // Closing the device in the middle of a run must leave the run intact.
    task automatic test_closed_mid_run();
        send_run(pick_side(), 0, RUN_LEN / 2);
        wait_drained();
        cfg_access(1'b1, tkbd_pkg::ADDR_ENABLE, 32'd0);
        repeat (8) send_noise();
        wait_drained();
        cfg_access(1'b1, tkbd_pkg::ADDR_ENABLE, 32'd1);
        send_run(dir_q, 0, 2 * RUN_LEN);
        wait_drained();
    endtask

    // Phases at different gates with full runs, broken runs, pop bursts and
    // stray transactions.
    task automatic test_random_mix();
        int unsigned    start;
        int unsigned    roll;
        tkbd_pkg::dir_t side;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'd0);
                1:       cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'd65535);
                2:       cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'd1);
                3:       cfg_access(1'b1, tkbd_pkg::ADDR_GATE, 32'(tkbd_pkg::GATE_RESET));
                7:       cfg_access(1'b1, tkbd_pkg::ADDR_GATE, $urandom_range(MAX_CAPTURE));
                default: cfg_access(1'b1, tkbd_pkg::ADDR_GATE, $urandom_range(400));
            endcase
            start = items_sent;
            while (items_sent - start < 40) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    side = pick_side();
                    if (side == tkbd_pkg::DIR_IDLE)
                        send_noise();
                    else
                        send_run(side, $urandom_range(25), 2 * RUN_LEN);
                end else if (roll < 75) begin
                    // A run cut short; the next episode usually breaks it.
                    send_run(pick_side(), 5, $urandom_range(RUN_LEN - 1, 1));
                end else if (roll < 88) begin
                    repeat ($urandom_range(6, 1)) send_item(tkbd_pkg::CMD_POP, 16'($urandom));
                end else begin
                    repeat ($urandom_range(8, 1)) send_noise();
                end
            end
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, let the pipeline settle,
    // then report.
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_closed_device();
        test_field_extremes();
        test_event_overflow();
        test_back_pressure();
        test_closed_mid_run();
        test_random_mix();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tkbd_pkg.sv
rtl/core/tkbd_front.sv
rtl/core/tkbd_div.sv
rtl/core/tkbd_back.sv
rtl/core/touch_key_baseline_detector_core.sv
tb/tb_touch_key_baseline_detector_core.sv
